[rtl/lfsa_pkg.sv]
// Shared constants and types for the lowest-free-slot interval allocator.
package lfsa_pkg;

  localparam int MAX_SLOTS_DEF = 64;
  localparam int TIME_BITS_DEF = 32;

  localparam int CFG_W      = 7;
  localparam int SLOT_IDX_W = 6;

  localparam logic [CFG_W-1:0] SLOTS_IN_USE_RST = 7'd64;

  // Per-cell outcome for the request currently sitting at the cell's input.
  typedef struct packed {
    logic grant;
    logic refuse;
  } cell_stat_t;

endpackage

[rtl/lfsa_cell.sv]
// One slot cell: holds its busy-until time and used flag, passes the request on when enabled but busy.
module lfsa_cell #(
  parameter int TIME_BITS = lfsa_pkg::TIME_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  clr,
  input  logic                  en,
  input  logic                  up_act,
  input  logic [TIME_BITS-1:0]  up_start,
  input  logic [TIME_BITS-1:0]  up_stop,
  output logic                  dn_act,
  output logic [TIME_BITS-1:0]  dn_start,
  output logic [TIME_BITS-1:0]  dn_stop,
  output lfsa_pkg::cell_stat_t  stat
);
  import lfsa_pkg::*;

  logic                 used_r;
  logic [TIME_BITS-1:0] busy_until_r;
  logic                 act_r;
  logic                 act_nxt;
  logic [TIME_BITS-1:0] start_r;
  logic [TIME_BITS-1:0] stop_r;
  logic                 slot_free;

  always_comb begin
    slot_free   = !used_r || (busy_until_r <= up_start);
    stat.grant  = up_act && en && slot_free;
    stat.refuse = up_act && !en;
    // advance to the next cell only when this slot is enabled but busy
    act_nxt     = up_act && en && !slot_free;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r <= 1'b0;
      act_r  <= 1'b0;
    end else begin
      act_r <= act_nxt;
      if (clr) begin
        used_r <= 1'b0;
      end else if (stat.grant) begin
        used_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (stat.grant) begin
      busy_until_r <= up_stop;
    end
    start_r <= up_start;
    stop_r  <= up_stop;
  end

  assign dn_act   = act_r;
  assign dn_start = start_r;
  assign dn_stop  = stop_r;

endmodule

[rtl/lowest_free_slot_interval_allocator.sv]
// Lowest-free-slot interval allocator: request walks a chain of slot cells, one cell per cycle.
// Path: the input transfer is registered into the request register; the request then steps
//   through one cell register per busy slot walked before the granting cell (or before the first
//   disabled cell, or past the last cell, for a refusal); the outcome goes to the result register.
// Throughput: one item in flight; the next transfer is taken once the result is in the result register.
// Reset: all slots free, slots_in_use = 64, no item in flight, no result pending.
module lowest_free_slot_interval_allocator #(
  parameter int MAX_SLOTS = lfsa_pkg::MAX_SLOTS_DEF,
  parameter int TIME_BITS = lfsa_pkg::TIME_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [lfsa_pkg::CFG_W-1:0]     cfg_slots_in_use,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic                           in_new_run,
  input  logic [TIME_BITS-1:0]           in_start_time,
  input  logic [TIME_BITS-1:0]           in_end_time,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic                           out_granted,
  output logic [lfsa_pkg::SLOT_IDX_W-1:0] out_slot_index
);
  import lfsa_pkg::*;

  localparam int IDX_W = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;

  logic [CFG_W-1:0]     slots_in_use_r;
  logic                 busy_r;
  logic                 req_act_r;
  logic [TIME_BITS-1:0] req_start_r;
  logic [TIME_BITS-1:0] req_stop_r;

  logic                  out_valid_r;
  logic                  out_granted_r;
  logic [SLOT_IDX_W-1:0] out_slot_index_r;
  logic                  pend_valid_r;
  logic                  pend_granted_r;
  logic [SLOT_IDX_W-1:0] pend_slot_index_r;

  logic                 ch_act   [MAX_SLOTS+1];
  logic [TIME_BITS-1:0] ch_start [MAX_SLOTS+1];
  logic [TIME_BITS-1:0] ch_stop  [MAX_SLOTS+1];
  cell_stat_t           stat     [MAX_SLOTS];
  logic [MAX_SLOTS-1:0] en_vec;

  logic                  in_xfer;
  logic                  out_xfer;
  logic                  clr_all;
  logic                  done;
  logic                  done_granted;
  logic [IDX_W-1:0]      grant_idx;
  logic [SLOT_IDX_W-1:0] done_slot_index;

  assign in_xfer  = in_valid && !in_stall;
  assign out_xfer = out_valid_r && !out_stall;
  assign in_stall = busy_r || pend_valid_r;
  assign clr_all  = in_xfer && in_new_run;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slots_in_use_r <= SLOTS_IN_USE_RST;
    end else if (cfg_we) begin
      slots_in_use_r <= cfg_slots_in_use;
    end
  end

  // Cells past the enabled count refuse; a count above MAX_SLOTS saturates naturally.
  for (genvar k = 0; k < MAX_SLOTS; k++) begin : g_en
    if (k >= (1 << CFG_W)) begin : g_off
      assign en_vec[k] = 1'b0;
    end else begin : g_cmp
      assign en_vec[k] = slots_in_use_r > CFG_W'(k);
    end
  end

  assign ch_act[0]   = req_act_r;
  assign ch_start[0] = req_start_r;
  assign ch_stop[0]  = req_stop_r;

  for (genvar k = 0; k < MAX_SLOTS; k++) begin : g_cell
    lfsa_cell #(
      .TIME_BITS (TIME_BITS)
    ) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .clr      (clr_all),
      .en       (en_vec[k]),
      .up_act   (ch_act[k]),
      .up_start (ch_start[k]),
      .up_stop  (ch_stop[k]),
      .dn_act   (ch_act[k+1]),
      .dn_start (ch_start[k+1]),
      .dn_stop  (ch_stop[k+1]),
      .stat     (stat[k])
    );
  end

  // At most one cell is active, so the outcome is a plain OR over the row.
  always_comb begin
    done_granted = 1'b0;
    done         = ch_act[MAX_SLOTS];
    grant_idx    = '0;
    for (int k = 0; k < MAX_SLOTS; k++) begin
      done_granted = done_granted | stat[k].grant;
      done         = done | stat[k].grant | stat[k].refuse;
      if (stat[k].grant) begin
        grant_idx = grant_idx | IDX_W'(k);
      end
    end
    done_slot_index = SLOT_IDX_W'(grant_idx);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r    <= 1'b0;
      req_act_r <= 1'b0;
    end else begin
      req_act_r <= in_xfer;
      if (in_xfer) begin
        busy_r <= 1'b1;
      end else if (done) begin
        busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      req_start_r <= in_start_time;
      req_stop_r  <= in_end_time;
    end
  end

  // Result register plus one holding slot for a result finished while the output stalls.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      pend_valid_r <= 1'b0;
    end else begin
      if (!out_valid_r || out_xfer) begin
        if (pend_valid_r) begin
          out_valid_r  <= 1'b1;
          pend_valid_r <= 1'b0;
        end else begin
          out_valid_r <= done;
        end
      end else if (done) begin
        pend_valid_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid_r || out_xfer) begin
      if (pend_valid_r) begin
        out_granted_r    <= pend_granted_r;
        out_slot_index_r <= pend_slot_index_r;
      end else if (done) begin
        out_granted_r    <= done_granted;
        out_slot_index_r <= done_slot_index;
      end
    end else if (done) begin
      pend_granted_r    <= done_granted;
      pend_slot_index_r <= done_slot_index;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_granted    = out_granted_r;
  assign out_slot_index = out_slot_index_r;

endmodule
